[rtl/fpcs_pkg.sv]
// Shared widths and constants for the farthest point chord split block.
`default_nettype none
package fpcs_pkg;

	localparam int COORD_W       = 16;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int DIST_W        = 17;
	localparam int INDEX_W       = 10;
	localparam int FRACTION_BITS = 10;

	// operand and product of the shared multiplier
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;

	// sums of two 17x17 products stay below 2^33
	localparam int SUM_W  = 2 * DIFF_W;
	localparam int MAG_W  = SUM_W - 1;
	localparam int QUAD_W = 2 * MAG_W;
	localparam int RAD_W  = 2 * DIST_W;

	localparam logic [DIST_W-1:0] THR_RESET = DIST_W'((5 * (1 << FRACTION_BITS)) / 100);

endpackage
`default_nettype wire

[rtl/fpcs_in_if.sv]
// Point channel: interior point, chord end points and segment end flag.
`default_nettype none
interface fpcs_in_if import fpcs_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic                      last_point;

	modport source (
		output valid, point_x, point_y, start_x, start_y, end_x, end_y, last_point,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, start_x, start_y, end_x, end_y, last_point,
		output ready
	);

endinterface
`default_nettype wire

[rtl/fpcs_out_if.sv]
// Result channel: split decision, farthest index and distance.
`default_nettype none
interface fpcs_out_if import fpcs_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               split_needed;
	logic [INDEX_W-1:0] farthest_index;
	logic [DIST_W-1:0]  farthest_distance;

	modport source (
		output valid, split_needed, farthest_index, farthest_distance,
		input  ready
	);

	modport sink (
		input  valid, split_needed, farthest_index, farthest_distance,
		output ready
	);

endinterface
`default_nettype wire

[rtl/fpcs_mul.sv]
// Shared signed 18x18 multiplier with registered product.
`default_nettype none
module fpcs_mul import fpcs_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule
`default_nettype wire

[rtl/fpcs_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must fit MAG_W bits.
`default_nettype none
module fpcs_div import fpcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QUAD_W-1:0] dividend,
	input  logic [MAG_W-1:0]  divisor,
	output logic [MAG_W-1:0]  quotient,
	output logic              done
);

	localparam int CNT_W = $clog2(MAG_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] dvd_q;
	logic [MAG_W-1:0] den_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W:0]   r2;
	logic [MAG_W:0]   diff;
	logic             ge;

	assign r2   = {rem_q, dvd_q[MAG_W-1]};
	assign ge   = r2 >= {1'b0, den_q};
	assign diff = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[QUAD_W-1:MAG_W];
			dvd_q <= dividend[MAG_W-1:0];
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
			dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

[rtl/fpcs_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle, truncated.
`default_nettype none
module fpcs_sqrt import fpcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [DIST_W-1:0] root,
	output logic              done
);

	localparam int CNT_W = $clog2(DIST_W);
	localparam int REM_W = DIST_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIST_W-1:0] root_q;
	logic [REM_W+1:0]  r2;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;

	assign r2    = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {(REM_W - DIST_W)'(0), root_q, 2'b01};
	assign ge    = r2 >= trial;
	assign diff  = r2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays at or below twice the partial root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
			root_q <= {root_q[DIST_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
`default_nettype wire

[rtl/farthest_point_chord_split.sv]
// Top level: sequencer, shared multiplier, divider and square root unit.
// One item at a time; ready only while idle. When the point lies beyond a chord end
// or the chord is degenerate, an item takes 15 multiplier steps and then 17 root
// steps; on the perpendicular path the 33-step divider runs before the root. Async
// reset clears control state, the running maximum and position; the threshold
// resets to 0.05 m.
`default_nettype none
module farthest_point_chord_split import fpcs_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DIST_W-1:0] cfg_wdata,
	fpcs_in_if.sink           points,
	fpcs_out_if.source        result
);

	localparam int              PW        = $clog2(MAX_POINTS);
	localparam logic [PW-1:0]   POS_MAX   = PW'(MAX_POINTS - 2);
	localparam logic [PW-1:0]   POS_FIRST = PW'(1);
	localparam logic [3:0]      STEP_LAST = 4'd14;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIV  = 5'b00100,
		S_SQRT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;

	logic [DIST_W-1:0] thr_q;
	logic [DIST_W-1:0] best_q;
	logic [PW-1:0]     best_idx_q;
	logic [PW-1:0]     pos_q;

	logic                     out_valid_q;
	logic                     split_needed_q;
	logic [INDEX_W-1:0]       far_idx_q;
	logic [DIST_W-1:0]        farthest_q;

	logic signed [DIFF_W-1:0] dx_q, dy_q, cx_q, cy_q, fx_q, fy_q;
	logic                     last_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  dot_q;
	logic signed [SUM_W-1:0]  cross_q;
	logic [MAG_W-1:0]         cmag_q;
	logic [MAG_W-1:0]         to_start_q;
	logic [MAG_W-1:0]         to_end_q;
	logic [MAG_W-1:0]         len2_q;
	logic [QUAD_W-1:0]        sq_q;

	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  p_sum;
	logic [SUM_W-1:0]         p_raw;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  dif;
	logic signed [SUM_W-1:0]  cross_neg;

	logic                     degen, behind, past, no_div;
	logic                     div_start, div_done;
	logic [MAG_W-1:0]         quotient;
	logic                     sqrt_start, sqrt_done;
	logic [RAD_W-1:0]         radicand;
	logic [DIST_W-1:0]        root;

	logic                     accept;
	logic                     upd;
	logic [DIST_W-1:0]        new_best;
	logic [PW-1:0]            new_idx;
	logic [PW+INDEX_W-1:0]    idx_wide;
	logic                     emit;

	assign accept = points.valid && points.ready;
	assign points.ready = (state_q == S_IDLE);

	fpcs_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// product schedule: issue at step k, consumed at step k+1
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			4'd0:  begin op_a = MUL_W'(dx_q); op_b = MUL_W'(dx_q); end
			4'd1:  begin op_a = MUL_W'(dy_q); op_b = MUL_W'(dy_q); end
			4'd2:  begin op_a = MUL_W'(cx_q); op_b = MUL_W'(cx_q); end
			4'd3:  begin op_a = MUL_W'(cy_q); op_b = MUL_W'(cy_q); end
			4'd4:  begin op_a = MUL_W'(dx_q); op_b = MUL_W'(cx_q); end
			4'd5:  begin op_a = MUL_W'(dy_q); op_b = MUL_W'(cy_q); end
			4'd6:  begin op_a = MUL_W'(cx_q); op_b = MUL_W'(dy_q); end
			4'd7:  begin op_a = MUL_W'(cy_q); op_b = MUL_W'(dx_q); end
			4'd8:  begin op_a = MUL_W'(fx_q); op_b = MUL_W'(fx_q); end
			4'd9:  begin op_a = MUL_W'(fy_q); op_b = MUL_W'(fy_q); end
			4'd10: begin
				op_a = {1'b0, cmag_q[DIFF_W-1:0]};
				op_b = {1'b0, cmag_q[DIFF_W-1:0]};
			end
			4'd11: begin
				op_a = {2'b00, cmag_q[MAG_W-1:DIFF_W]};
				op_b = {1'b0, cmag_q[DIFF_W-1:0]};
			end
			4'd12: begin
				op_a = {2'b00, cmag_q[MAG_W-1:DIFF_W]};
				op_b = {2'b00, cmag_q[MAG_W-1:DIFF_W]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign p_raw     = prod_s1[SUM_W-1:0];
	assign p_sum     = prod_s1[SUM_W-1:0];
	assign sum       = acc_q + p_sum;
	assign dif       = acc_q - p_sum;
	assign cross_neg = -cross_q;

	assign degen  = (len2_q == '0);
	assign behind = dot_q[SUM_W-1];
	assign past   = dot_q > $signed({1'b0, len2_q});
	assign no_div = degen || behind || past;

	assign div_start  = (state_q == S_MUL) && (step_q == STEP_LAST) && !no_div;
	assign sqrt_start = ((state_q == S_MUL) && (step_q == STEP_LAST) && no_div)
		|| ((state_q == S_DIV) && div_done);

	always_comb begin
		if (state_q == S_DIV) begin
			radicand = {1'b0, quotient};
		end else if (degen || behind) begin
			radicand = {1'b0, to_start_q};
		end else begin
			radicand = {1'b0, to_end_q};
		end
	end

	fpcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sq_q),
		.divisor  (len2_q),
		.quotient (quotient),
		.done     (div_done)
	);

	fpcs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.root     (root),
		.done     (sqrt_done)
	);

	assign upd      = root > best_q;
	assign new_best = upd ? root : best_q;
	assign new_idx  = upd ? pos_q : best_idx_q;
	assign idx_wide = {{INDEX_W{1'b0}}, new_idx};
	assign emit     = (state_q == S_DONE) && last_q && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			thr_q       <= THR_RESET;
			best_q      <= '0;
			best_idx_q  <= POS_FIRST;
			pos_q       <= POS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= no_div ? S_SQRT : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!last_q) begin
						best_q     <= new_best;
						best_idx_q <= new_idx;
						if (pos_q < POS_MAX) begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= S_IDLE;
					end else if (emit) begin
						best_q     <= '0;
						best_idx_q <= POS_FIRST;
						pos_q      <= POS_FIRST;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q   <= DIFF_W'(points.point_x) - DIFF_W'(points.start_x);
			dy_q   <= DIFF_W'(points.point_y) - DIFF_W'(points.start_y);
			cx_q   <= DIFF_W'(points.end_x) - DIFF_W'(points.start_x);
			cy_q   <= DIFF_W'(points.end_y) - DIFF_W'(points.start_y);
			fx_q   <= DIFF_W'(points.point_x) - DIFF_W'(points.end_x);
			fy_q   <= DIFF_W'(points.point_y) - DIFF_W'(points.end_y);
			last_q <= points.last_point;
		end
		if (state_q == S_MUL) begin
			unique case (step_q)
				4'd1, 4'd3, 4'd5, 4'd7: acc_q <= p_sum;
				4'd2:  to_start_q <= sum[MAG_W-1:0];
				4'd4:  len2_q     <= sum[MAG_W-1:0];
				4'd6:  dot_q      <= sum;
				4'd8:  cross_q    <= dif;
				4'd9: begin
					acc_q  <= p_sum;
					cmag_q <= cross_q[SUM_W-1] ? cross_neg[MAG_W-1:0] : cross_q[MAG_W-1:0];
				end
				4'd10: to_end_q <= sum[MAG_W-1:0];
				4'd11: sq_q     <= QUAD_W'(p_raw);
				4'd12: sq_q     <= sq_q + (QUAD_W'(p_raw) << (DIFF_W + 1));
				4'd13: sq_q     <= sq_q + (QUAD_W'(p_raw) << (2 * DIFF_W));
				default: ;
			endcase
		end
		if (emit) begin
			split_needed_q <= new_best > thr_q;
			far_idx_q      <= idx_wide[INDEX_W-1:0];
			farthest_q     <= new_best;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.split_needed      = split_needed_q;
	assign result.farthest_index    = far_idx_q;
	assign result.farthest_distance = farthest_q;

endmodule
`default_nettype wire

[rtl/fpcs_chk.sv]
// Port-level checks for the farthest point chord split block, with bind.
`default_nettype none
module fpcs_chk import fpcs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               split_needed,
	input logic [INDEX_W-1:0] farthest_index,
	input logic [DIST_W-1:0]  farthest_distance
);

	// the block turns busy once it takes an item and drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an item was taken");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared one cycle after an item was taken");

	a_zero_dist_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (farthest_distance == '0)
			|-> (farthest_index == INDEX_W'(1)) && !split_needed)
		else $error("zero distance result with index other than first or split set");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(split_needed)
			&& $stable(farthest_index) && $stable(farthest_distance))
		else $error("stalled result changed or dropped");

	a_drop_on_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

endmodule

bind farthest_point_chord_split fpcs_chk u_fpcs_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (points.valid),
	.in_ready          (points.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.split_needed      (result.split_needed),
	.farthest_index    (result.farthest_index),
	.farthest_distance (result.farthest_distance)
);
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for farthest_point_chord_split: directed and random segments.
`timescale 1ns / 1ps
module tb;
	import fpcs_pkg::*;

	localparam int MAX_POINTS  = 1024;
	localparam int POS_CAP     = MAX_POINTS - 2;
	localparam int HOLD_OFF    = 100;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int BLOCK_ITEMS = 125;

	typedef struct {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      last_point;
	} chord_point_t;

	typedef struct {
		logic               split_needed;
		logic [INDEX_W-1:0] farthest_index;
		logic [DIST_W-1:0]  farthest_distance;
	} split_report_t;

	typedef enum {SEG_WIDE, SEG_NEAR, SEG_DEGEN, SEG_WILD} seg_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [DIST_W-1:0] cfg_wdata;

	fpcs_in_if  points_if ();
	fpcs_out_if result_if ();

	farthest_point_chord_split #(.MAX_POINTS(MAX_POINTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.points    (points_if),
		.result    (result_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	chord_point_t  point_q[$];
	chord_point_t  sent_point;
	split_report_t split_reports_q[$];

	// running farthest-point state and threshold as the block should hold them
	logic [DIST_W-1:0]  threshold = THR_RESET;
	logic [DIST_W-1:0]  best_dist = '0;
	logic [INDEX_W-1:0] best_index = INDEX_W'(1);
	int                 position = 1;

	int src_idle = 0;
	int snk_idle = 0;
	int fail_count = 0;
	int points_taken = 0;
	int segments_done = 0;
	int splits_flagged = 0;
	int cycle_count = 0;

	function automatic logic [DIST_W-1:0] floor_root(longint unsigned n);
		longint unsigned r, cand;
		r = 0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= n)
				r = cand;
		end
		return r[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] chord_distance(chord_point_t p);
		longint            dx, dy, cx, cy, fx, fy, dot, cprod;
		longint unsigned   len2;
		logic [127:0]      cprod_sq, lhs;
		logic [DIST_W-1:0] q, cand;
		dx = longint'(p.point_x) - longint'(p.start_x);
		dy = longint'(p.point_y) - longint'(p.start_y);
		cx = longint'(p.end_x) - longint'(p.start_x);
		cy = longint'(p.end_y) - longint'(p.start_y);
		len2 = cx * cx + cy * cy;
		dot = dx * cx + dy * cy;
		if (len2 == 0 || dot < 0)
			return floor_root(dx * dx + dy * dy);
		if (dot > longint'(len2)) begin
			fx = longint'(p.point_x) - longint'(p.end_x);
			fy = longint'(p.point_y) - longint'(p.end_y);
			return floor_root(fx * fx + fy * fy);
		end
		cprod = cx * dy - cy * dx;
		if (cprod < 0)
			cprod = -cprod;
		cprod_sq = 128'(cprod) * 128'(cprod);
		q = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			cand = q | (DIST_W'(1) << b);
			lhs = 128'(cand) * 128'(cand) * 128'(len2);
			if (lhs <= cprod_sq)
				q = cand;
		end
		return q;
	endfunction

	function automatic void take_point(chord_point_t p);
		logic [DIST_W-1:0] d;
		split_report_t     r;
		d = chord_distance(p);
		if (d > best_dist) begin
			best_dist = d;
			best_index = INDEX_W'(position);
		end
		if (!p.last_point) begin
			if (position < POS_CAP)
				position++;
		end else begin
			r.split_needed = best_dist > threshold;
			r.farthest_index = best_index;
			r.farthest_distance = best_dist;
			split_reports_q = {split_reports_q, r};
			splits_flagged += int'(r.split_needed);
			segments_done++;
			best_dist = '0;
			best_index = INDEX_W'(1);
			position = 1;
		end
	endfunction

	function automatic chord_point_t make_point(int px, int py, int sx, int sy, int ex, int ey,
			logic last);
		chord_point_t p;
		p.point_x = COORD_W'(px);
		p.point_y = COORD_W'(py);
		p.start_x = COORD_W'(sx);
		p.start_y = COORD_W'(sy);
		p.end_x = COORD_W'(ex);
		p.end_y = COORD_W'(ey);
		p.last_point = last;
		return p;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int wide_coord();
		logic signed [COORD_W-1:0] v;
		v = COORD_W'($urandom);
		return int'(v);
	endfunction

	function automatic int jitter(int m);
		return int'($urandom_range(2 * m)) - m;
	endfunction

	task automatic new_chord(output int sx, output int sy, output int ex, output int ey);
		sx = wide_coord();
		sy = wide_coord();
		if ($urandom_range(1)) begin
			ex = wide_coord();
			ey = wide_coord();
		end else begin
			ex = clamp_coord(sx + jitter(4000));
			ey = clamp_coord(sy + jitter(4000));
		end
	endtask

	task automatic add_segment(seg_kind_t kind, int n);
		int sx, sy, ex, ey, px, py, t, off;
		new_chord(sx, sy, ex, ey);
		if (kind == SEG_DEGEN) begin
			ex = sx;
			ey = sy;
		end
		for (int i = 1; i <= n; i++) begin
			if (kind == SEG_WILD)
				new_chord(sx, sy, ex, ey);
			if (kind == SEG_WIDE || (kind != SEG_NEAR && $urandom_range(1))) begin
				px = wide_coord();
				py = wide_coord();
			end else begin
				t = int'($urandom_range(1536)) - 256;
				off = jitter(90);
				if (i >= POS_CAP)
					off = off + (i - POS_CAP + 1) * 400;
				px = clamp_coord(sx + ((ex - sx) * t) / 1024 + jitter(90));
				py = clamp_coord(sy + ((ey - sy) * t) / 1024 + off);
			end
			point_q = {point_q, make_point(px, py, sx, sy, ex, ey, i == n)};
		end
	endtask

	task automatic wait_idle();
		while (point_q.size() != 0 || points_if.valid || split_reports_q.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_threshold(logic [DIST_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		threshold = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// point driver
	always @(posedge clk) begin
		logic send;
		if (arst_n) begin
			if (points_if.valid && points_if.ready) begin
				take_point(sent_point);
				points_taken++;
			end
			if (!points_if.valid || points_if.ready) begin
				send = point_q.size() != 0 && $urandom_range(99) >= src_idle;
				if (send) begin
					sent_point = point_q.pop_front();
					points_if.point_x <= sent_point.point_x;
					points_if.point_y <= sent_point.point_y;
					points_if.start_x <= sent_point.start_x;
					points_if.start_y <= sent_point.start_y;
					points_if.end_x <= sent_point.end_x;
					points_if.end_y <= sent_point.end_y;
					points_if.last_point <= sent_point.last_point;
				end
				points_if.valid <= send;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		split_report_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (split_reports_q.size() == 0) begin
					$error("result with no segment pending: farthest_index %0d, distance %0d",
						result_if.farthest_index, result_if.farthest_distance);
					fail_count++;
				end else begin
					want = split_reports_q.pop_front();
					if (result_if.split_needed !== want.split_needed) begin
						$error("split_needed: expected %0d, got %0d", want.split_needed,
							result_if.split_needed);
						fail_count++;
					end
					if (result_if.farthest_index !== want.farthest_index) begin
						$error("farthest_index: expected %0d, got %0d", want.farthest_index,
							result_if.farthest_index);
						fail_count++;
					end
					if (result_if.farthest_distance !== want.farthest_distance) begin
						$error("farthest_distance: expected %0d, got %0d",
							want.farthest_distance, result_if.farthest_distance);
						fail_count++;
					end
				end
			end
			result_if.ready <= $urandom_range(99) >= snk_idle;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [DIST_W-1:0] thr_plan[6];
		int                queued, n, pick;
		seg_kind_t         kind;
		points_if.valid = 1'b0;
		points_if.point_x = '0;
		points_if.point_y = '0;
		points_if.start_x = '0;
		points_if.start_y = '0;
		points_if.end_x = '0;
		points_if.end_y = '0;
		points_if.last_point = 1'b0;
		result_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		thr_plan[0] = '1;
		thr_plan[1] = '0;
		thr_plan[2] = DIST_W'($urandom_range(600));
		thr_plan[3] = DIST_W'(92682);
		thr_plan[4] = THR_RESET;
		thr_plan[5] = DIST_W'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed segments, reset threshold
		src_idle = 7;
		snk_idle = 82;
		point_q = {point_q, make_point(-32768, -32768, 32767, 32767, 32767, 32767, 1'b1)};
		point_q = {point_q, make_point(-500, 0, 0, 0, 1024, 0, 1'b0)};
		point_q = {point_q, make_point(2000, 300, 0, 0, 1024, 0, 1'b0)};
		point_q = {point_q, make_point(512, 40, 0, 0, 1024, 0, 1'b1)};
		point_q = {point_q, make_point(100, 60, 0, 0, 1000, 0, 1'b0)};
		point_q = {point_q, make_point(200, 60, 0, 0, 1000, 0, 1'b0)};
		point_q = {point_q, make_point(300, -60, 0, 0, 1000, 0, 1'b1)};
		point_q = {point_q, make_point(500, 51, 0, 0, 1000, 0, 1'b1)};
		point_q = {point_q, make_point(500, 52, 0, 0, 1000, 0, 1'b1)};
		point_q = {point_q, make_point(0, 0, 0, 0, 1000, 0, 1'b0)};
		point_q = {point_q, make_point(700, 0, 0, 0, 1000, 0, 1'b1)};
		point_q = {point_q, make_point(32767, 32767, -32768, 32767, 32767, -32768, 1'b0)};
		point_q = {point_q, make_point(-32768, -32768, -32768, 32767, 32767, -32768, 1'b1)};
		point_q = {point_q, make_point(-4, 3, 0, 0, 3, 4, 1'b0)};
		point_q = {point_q, make_point(1, 1, 0, 0, 3, 4, 1'b1)};
		wait_idle();

		for (int blk = 0; blk < 6; blk++) begin
			src_idle = (blk < 2) ? 7 : (blk < 4) ? 82 : 0;
			snk_idle = (blk < 2) ? 82 : (blk < 4) ? 7 : 0;
			write_threshold(thr_plan[blk]);
			// one segment long enough to saturate the point position
			if (blk == 4)
				add_segment(SEG_NEAR, MAX_POINTS + 6);
			queued = 0;
			while (queued < BLOCK_ITEMS) begin
				pick = $urandom_range(99);
				kind = (pick < 45) ? SEG_NEAR : (pick < 75) ? SEG_WIDE :
					(pick < 88) ? SEG_DEGEN : SEG_WILD;
				n = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
				add_segment(kind, n);
				queued += n;
			end
			wait_idle();
		end

		$display("%0d points in %0d segments, %0d flagged for a split", points_taken,
			segments_done, splits_flagged);
		$display("thresholds from zero to all ones, sender and receiver stalls both ways");
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
